>>> design/rsi_pkg.sv
// Package for the ray/sphere intersection pipeline: number format, widths, stage counts,
// register indexes, saturating Q arithmetic and the step functions of the iterative units.
// Depends on nothing.
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NORM_BITS = FRAC_BITS + 2;
  localparam int RADIUS_W  = WORD_BITS - 1;
  localparam int MAGW      = 2 * WORD_BITS + FRAC_BITS;

  localparam int SQ_PAIRS = (WORD_BITS + FRAC_BITS + 1) / 2;
  localparam int SQ_RW    = SQ_PAIRS + 3;
  localparam int SQ_STG   = (SQ_PAIRS + 1) / 2;

  localparam int DV_BITS = WORD_BITS + FRAC_BITS;
  localparam int DV_STG  = (DV_BITS + 1) / 2;

  localparam int NRM_TOP  = 30;
  localparam int NRM_POS  = NRM_TOP - 1;
  localparam int POS_W    = $clog2(WORD_BITS);
  localparam int SUM_W    = 2 * NRM_TOP + 2;
  localparam int IS_PAIRS = SUM_W / 2;
  localparam int IS_RW    = IS_PAIRS + 3;
  localparam int IS_STG   = (IS_PAIRS + 1) / 2;
  localparam int LEN_W    = IS_PAIRS;
  localparam int NQ_BITS  = FRAC_BITS + 1;
  localparam int NDIV_W   = NRM_TOP + FRAC_BITS + 1;
  localparam int NQ_STG   = (NQ_BITS + 1) / 2;

  localparam int IN_TW  = ((6 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_W  = 4 * WORD_BITS + 3 * NORM_BITS;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [WORD_BITS-1:0] q_t;
  typedef logic [WORD_BITS-1:0]        qm_t;
  typedef logic signed [NORM_BITS-1:0] nrm_t;

  localparam q_t QMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [RADIUS_W-1:0] RAD_ONE = RADIUS_W'(1) << FRAC_BITS;
  localparam nrm_t NRM_ONE = NORM_BITS'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS
  } reg_idx_e;

  typedef struct packed {
    logic [SQ_RW-1:0]    rem;
    logic [SQ_PAIRS-1:0] root;
  } sq_rr_t;

  typedef struct packed {
    logic [IS_RW-1:0]    rem;
    logic [IS_PAIRS-1:0] root;
  } is_rr_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [DV_BITS-1:0]   quo;
  } dv_rq_t;

  typedef struct packed {
    logic [LEN_W-1:0]   rem;
    logic [NQ_BITS-1:0] quo;
  } nq_rq_t;

  typedef struct {
    q_t   s [3];
    q_t   d [3];
    q_t   negb;
    q_t   twoa;
    logic miss;
  } ray_t;

  typedef struct {
    ray_t   ray;
    q_t     v;
    sq_rr_t rr;
  } sq_t;

  typedef struct {
    q_t     s [3];
    q_t     d [3];
    logic   miss;
    logic   neg;
    qm_t    den;
    qm_t    num;
    dv_rq_t rq;
  } dv_t;

  typedef struct {
    q_t         t;
    q_t         p [3];
    logic       miss;
    logic [2:0] sgn;
    logic       zero;
  } nm_t;

  typedef struct {
    nm_t                nm;
    logic [NRM_TOP-1:0] u [3];
    logic [SUM_W-1:0]   sum;
    is_rr_t             rr;
  } is_t;

  typedef struct {
    nm_t                nm;
    logic [LEN_W-1:0]   len;
    logic [NQ_BITS-1:0] lo [3];
    nq_rq_t             rq [3];
  } nq_t;

  function automatic q_t sat_w(logic [WORD_BITS:0] v);
    if (v[WORD_BITS] != v[WORD_BITS-1]) return v[WORD_BITS] ? QMIN : QMAX;
    return q_t'(v[WORD_BITS-1:0]);
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    return sat_w({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    return sat_w({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
  endfunction

  function automatic qm_t q_mag(q_t a);
    return a[WORD_BITS-1] ? qm_t'(-a) : qm_t'(a);
  endfunction

  function automatic q_t from_mag(logic [MAGW-1:0] m, logic neg);
    logic [MAGW-1:0] lim;
    logic [MAGW-1:0] mm;
    lim = {{(MAGW-WORD_BITS){1'b0}}, neg, {(WORD_BITS-1){~neg}}};
    mm  = (m > lim) ? lim : m;
    return neg ? q_t'(-mm[WORD_BITS-1:0]) : q_t'(mm[WORD_BITS-1:0]);
  endfunction

  function automatic q_t q_mul(q_t a, q_t b);
    logic [2*WORD_BITS-1:0] p;
    p = q_mag(a) * q_mag(b);
    return from_mag(MAGW'(p >> FRAC_BITS), a[WORD_BITS-1] ^ b[WORD_BITS-1]);
  endfunction

  function automatic q_t q_scale(q_t a, int sh);
    return from_mag(MAGW'(q_mag(a)) << sh, a[WORD_BITS-1]);
  endfunction

  function automatic sq_rr_t sq_step(sq_rr_t x, logic [1:0] two);
    logic [SQ_RW-1:0] r2;
    logic [SQ_RW-1:0] trial;
    sq_rr_t           y;
    r2    = {x.rem[SQ_RW-3:0], two};
    trial = SQ_RW'({x.root, 2'b01});
    if (r2 >= trial) begin
      y.rem  = r2 - trial;
      y.root = {x.root[SQ_PAIRS-2:0], 1'b1};
    end else begin
      y.rem  = r2;
      y.root = {x.root[SQ_PAIRS-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic is_rr_t is_step(is_rr_t x, logic [1:0] two);
    logic [IS_RW-1:0] r2;
    logic [IS_RW-1:0] trial;
    is_rr_t           y;
    r2    = {x.rem[IS_RW-3:0], two};
    trial = IS_RW'({x.root, 2'b01});
    if (r2 >= trial) begin
      y.rem  = r2 - trial;
      y.root = {x.root[IS_PAIRS-2:0], 1'b1};
    end else begin
      y.rem  = r2;
      y.root = {x.root[IS_PAIRS-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic dv_rq_t dv_step(dv_rq_t x, logic b, qm_t den);
    logic [WORD_BITS:0] r2;
    logic               ge;
    dv_rq_t             y;
    r2 = {x.rem, b};
    ge = (r2 >= {1'b0, den});
    if (ge) r2 = r2 - {1'b0, den};
    y.rem = r2[WORD_BITS-1:0];
    y.quo = {x.quo[DV_BITS-2:0], ge};
    return y;
  endfunction

  function automatic nq_rq_t nq_step(nq_rq_t x, logic b, logic [LEN_W-1:0] len);
    logic [LEN_W:0] r2;
    logic           ge;
    nq_rq_t         y;
    r2 = {x.rem, b};
    ge = (r2 >= {1'b0, len});
    if (ge) r2 = r2 - {1'b0, len};
    y.rem = r2[LEN_W-1:0];
    y.quo = {x.quo[NQ_BITS-2:0], ge};
    return y;
  endfunction

endpackage

>>> design/ray_sphere_intersect.sv
// Ray against sphere intersection in signed Q16.16, fully pipelined.
// Holds the sphere registers, the quadratic front end, the square root, divide and
// normalization pipelines and the output register. Depends on rsi_pkg.
//
// One ray enters per cycle and every ray yields one result item. Most of the
// pipeline depth comes from the four iterative units, each retiring two
// iterations per stage: the discriminant square root (12 stages), the 48-bit root
// divide (24 stages), the normal length square root (16 stages) and the three normal
// divides running side by side (9 stages). The whole pipeline holds while a result
// waits at the output. No clearing pass after reset.
`timescale 1ns / 1ps

module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z
  input  logic [IN_TW-1:0]     s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
  output logic [OUT_TW-1:0]    m_axis_tdata,
  // is_hit
  output logic [0:0]           m_axis_tuser
);

  localparam int NSTG = 6 + 1 + SQ_STG + 1 + DV_STG + 8 + 1 + IS_STG + 1 + NQ_STG + 1;
  localparam logic [POS_W-1:0] NRM_POS_P = POS_W'(NRM_POS);

  logic              adv;
  logic [NSTG-1:0]   vld_q;
  q_t                ctr_q [3];
  logic [RADIUS_W-1:0] rad_q;
  q_t                rad;

  q_t sa_s_q [3], sa_d_q [3];
  q_t sb_s_q [3], sb_d_q [3], sb_l_q [3];
  q_t sc_s_q [3], sc_d_q [3], sc_dd_q [3], sc_dl_q [3], sc_ll_q [3], sc_rr_q;
  q_t sd_s_q [3], sd_d_q [3], sd_a_q, sd_dl_q, sd_ll_q, sd_rr_q;
  q_t se_s_q [3], se_d_q [3], se_a_q, se_b_q, se_cc_q, se_a4_q;
  q_t sf_s_q [3], sf_d_q [3], sf_bb_q, sf_ac_q, sf_negb_q, sf_twoa_q;
  logic sf_apos_q;
  q_t   disc_d;

  sq_t sq_q [SQ_STG+1];
  dv_t dv_q [DV_STG+1];
  q_t  num_d;

  nm_t tt_nm_q, tm_nm_q, tp_nm_q, tw_nm_q, tu_nm_q, tl_nm_q, th_nm_q, ts_nm_q;
  q_t  tt_s_q [3], tt_d_q [3], tm_s_q [3], tm_td_q [3], tw_w_q [3];
  qm_t tu_u_q [3], tu_m_q, tl_u_q [3], mx_d;
  logic [POS_W-1:0] tl_pos_q, pos_d;
  logic [NRM_TOP-1:0]   th_u_q [3], ts_u_q [3];
  logic [2*NRM_TOP-1:0] ts_sq_q [3];

  is_t is_q [IS_STG+1];
  nq_t nq_q [NQ_STG+1];

  logic [NDIV_W-1:0] pdv_d [3];
  logic              o_hit_q;
  q_t                o_dist_q, o_pt_q [3];
  nrm_t              o_nrm_q [3];

  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign rad           = q_t'({1'b0, rad_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
      rad_q    <= RAD_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X: ctr_q[0] <= q_t'(cfg_wdata_i);
        REG_CENTER_Y: ctr_q[1] <= q_t'(cfg_wdata_i);
        REG_CENTER_Z: ctr_q[2] <= q_t'(cfg_wdata_i);
        REG_RADIUS:   rad_q    <= cfg_wdata_i[RADIUS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // quadratic front end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sa_s_q[i] <= q_t'(s_axis_tdata[i*WORD_BITS +: WORD_BITS]);
        sa_d_q[i] <= q_t'(s_axis_tdata[(i+3)*WORD_BITS +: WORD_BITS]);
        sb_s_q[i] <= sa_s_q[i];
        sb_d_q[i] <= sa_d_q[i];
        sb_l_q[i] <= q_sub(sa_s_q[i], ctr_q[i]);
        sc_s_q[i]  <= sb_s_q[i];
        sc_d_q[i]  <= sb_d_q[i];
        sc_dd_q[i] <= q_mul(sb_d_q[i], sb_d_q[i]);
        sc_dl_q[i] <= q_mul(sb_d_q[i], sb_l_q[i]);
        sc_ll_q[i] <= q_mul(sb_l_q[i], sb_l_q[i]);
        sd_s_q[i] <= sc_s_q[i];
        sd_d_q[i] <= sc_d_q[i];
        se_s_q[i] <= sd_s_q[i];
        se_d_q[i] <= sd_d_q[i];
        sf_s_q[i] <= se_s_q[i];
        sf_d_q[i] <= se_d_q[i];
      end
      sc_rr_q   <= q_mul(rad, rad);
      sd_a_q    <= q_add(q_add(sc_dd_q[0], sc_dd_q[1]), sc_dd_q[2]);
      sd_dl_q   <= q_add(q_add(sc_dl_q[0], sc_dl_q[1]), sc_dl_q[2]);
      sd_ll_q   <= q_add(q_add(sc_ll_q[0], sc_ll_q[1]), sc_ll_q[2]);
      sd_rr_q   <= sc_rr_q;
      se_a_q    <= sd_a_q;
      se_b_q    <= q_scale(sd_dl_q, 1);
      se_cc_q   <= q_sub(sd_ll_q, sd_rr_q);
      se_a4_q   <= q_scale(sd_a_q, 2);
      sf_bb_q   <= q_mul(se_b_q, se_b_q);
      sf_ac_q   <= q_mul(se_a4_q, se_cc_q);
      sf_negb_q <= q_sub('0, se_b_q);
      sf_twoa_q <= q_scale(se_a_q, 1);
      sf_apos_q <= !se_a_q[WORD_BITS-1] && (se_a_q != '0);
    end
  end

  assign disc_d = q_sub(sf_bb_q, sf_ac_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0].ray.s    <= sf_s_q;
      sq_q[0].ray.d    <= sf_d_q;
      sq_q[0].ray.negb <= sf_negb_q;
      sq_q[0].ray.twoa <= sf_twoa_q;
      sq_q[0].ray.miss <= disc_d[WORD_BITS-1] || !sf_apos_q;
      sq_q[0].v        <= disc_d;
      sq_q[0].rr       <= '0;
    end
  end

  // discriminant square root, two result bits per stage
  for (genvar j = 0; j < SQ_STG; j++) begin : g_sq
    localparam int IH   = SQ_PAIRS - 1 - 2 * j;
    localparam int IL   = IH - 1;
    localparam int IL_S = (IL >= 0) ? IL : 0;
    logic [2*SQ_PAIRS-1:0] vx;
    sq_t                   nx;
    always_comb begin
      vx = (2*SQ_PAIRS)'({sq_q[j].v, {FRAC_BITS{1'b0}}});
      nx = sq_q[j];
      nx.rr = sq_step(nx.rr, vx[2*IH +: 2]);
      if (IL >= 0) nx.rr = sq_step(nx.rr, vx[2*IL_S +: 2]);
    end
    always_ff @(posedge clk_i) begin
      if (adv) sq_q[j+1] <= nx;
    end
  end

  assign num_d = q_sub(sq_q[SQ_STG].ray.negb, from_mag(MAGW'(sq_q[SQ_STG].rr.root), 1'b0));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].s    <= sq_q[SQ_STG].ray.s;
      dv_q[0].d    <= sq_q[SQ_STG].ray.d;
      dv_q[0].miss <= sq_q[SQ_STG].ray.miss;
      dv_q[0].neg  <= num_d[WORD_BITS-1];
      dv_q[0].num  <= q_mag(num_d);
      dv_q[0].den  <= qm_t'(sq_q[SQ_STG].ray.twoa);
      dv_q[0].rq   <= '0;
    end
  end

  // root divide, two quotient bits per stage
  for (genvar j = 0; j < DV_STG; j++) begin : g_dv
    localparam int KH   = DV_BITS - 1 - 2 * j;
    localparam int KL   = KH - 1;
    localparam int KL_S = (KL >= 0) ? KL : 0;
    logic [DV_BITS-1:0] dx;
    dv_t                nx;
    always_comb begin
      dx = {dv_q[j].num, {FRAC_BITS{1'b0}}};
      nx = dv_q[j];
      nx.rq = dv_step(nx.rq, dx[KH], nx.den);
      if (KL >= 0) nx.rq = dv_step(nx.rq, dx[KL_S], nx.den);
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[j+1] <= nx;
    end
  end

  // hit distance, hit point, offset from the center and its normalizing shift
  always_comb begin
    mx_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (q_mag(tw_w_q[i]) > mx_d) mx_d = q_mag(tw_w_q[i]);
    end
  end

  always_comb begin
    pos_d = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (tu_m_q[k]) pos_d = POS_W'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tt_nm_q.t    <= from_mag(MAGW'(dv_q[DV_STG].rq.quo), dv_q[DV_STG].neg);
      tt_nm_q.miss <= dv_q[DV_STG].miss;
      tt_nm_q.sgn  <= '0;
      tt_nm_q.zero <= 1'b0;
      tt_s_q       <= dv_q[DV_STG].s;
      tt_d_q       <= dv_q[DV_STG].d;
      tm_nm_q      <= tt_nm_q;
      tm_s_q       <= tt_s_q;
      for (int i = 0; i < 3; i++) begin
        tt_nm_q.p[i]  <= '0;
        tm_td_q[i]    <= q_mul(tt_nm_q.t, tt_d_q[i]);
        tp_nm_q.p[i]  <= q_add(tm_s_q[i], tm_td_q[i]);
        tw_w_q[i]     <= q_sub(tp_nm_q.p[i], ctr_q[i]);
        tw_nm_q.sgn[i] <= q_sub(tp_nm_q.p[i], ctr_q[i]) < 0;
        tu_u_q[i]     <= q_mag(tw_w_q[i]);
        tl_u_q[i]     <= tu_u_q[i];
        th_u_q[i]     <= (tl_pos_q > NRM_POS_P)
                         ? NRM_TOP'(tl_u_q[i] >> (tl_pos_q - NRM_POS_P))
                         : NRM_TOP'(tl_u_q[i] << (NRM_POS_P - tl_pos_q));
        ts_u_q[i]     <= th_u_q[i];
        ts_sq_q[i]    <= th_u_q[i] * th_u_q[i];
      end
      tp_nm_q.t    <= tm_nm_q.t;
      tp_nm_q.miss <= tm_nm_q.miss;
      tp_nm_q.sgn  <= tm_nm_q.sgn;
      tp_nm_q.zero <= tm_nm_q.zero;
      tw_nm_q.t    <= tp_nm_q.t;
      tw_nm_q.p    <= tp_nm_q.p;
      tw_nm_q.miss <= tp_nm_q.miss;
      tw_nm_q.zero <= tp_nm_q.zero;
      tu_nm_q.t    <= tw_nm_q.t;
      tu_nm_q.p    <= tw_nm_q.p;
      tu_nm_q.miss <= tw_nm_q.miss;
      tu_nm_q.sgn  <= tw_nm_q.sgn;
      tu_nm_q.zero <= (mx_d == '0);
      tu_m_q       <= mx_d;
      tl_nm_q      <= tu_nm_q;
      tl_pos_q     <= pos_d;
      th_nm_q      <= tl_nm_q;
      ts_nm_q      <= th_nm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      is_q[0].nm  <= ts_nm_q;
      is_q[0].u   <= ts_u_q;
      is_q[0].sum <= SUM_W'(ts_sq_q[0]) + SUM_W'(ts_sq_q[1]) + SUM_W'(ts_sq_q[2]);
      is_q[0].rr  <= '0;
    end
  end

  // normal length square root, two result bits per stage
  for (genvar j = 0; j < IS_STG; j++) begin : g_is
    localparam int IH   = IS_PAIRS - 1 - 2 * j;
    localparam int IL   = IH - 1;
    localparam int IL_S = (IL >= 0) ? IL : 0;
    is_t nx;
    always_comb begin
      nx = is_q[j];
      nx.rr = is_step(nx.rr, nx.sum[2*IH +: 2]);
      if (IL >= 0) nx.rr = is_step(nx.rr, nx.sum[2*IL_S +: 2]);
    end
    always_ff @(posedge clk_i) begin
      if (adv) is_q[j+1] <= nx;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pdv_d[i] = NDIV_W'({is_q[IS_STG].u[i], {FRAC_BITS{1'b0}}})
               + NDIV_W'(is_q[IS_STG].rr.root >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nq_q[0].nm  <= is_q[IS_STG].nm;
      nq_q[0].len <= is_q[IS_STG].rr.root;
      for (int i = 0; i < 3; i++) begin
        nq_q[0].lo[i]     <= pdv_d[i][NQ_BITS-1:0];
        nq_q[0].rq[i].rem <= LEN_W'(pdv_d[i][NDIV_W-1:NQ_BITS]);
        nq_q[0].rq[i].quo <= '0;
      end
    end
  end

  // normal component divides, three lanes
  for (genvar j = 0; j < NQ_STG; j++) begin : g_nq
    localparam int KH   = NQ_BITS - 1 - 2 * j;
    localparam int KL   = KH - 1;
    localparam int KL_S = (KL >= 0) ? KL : 0;
    nq_t nx;
    always_comb begin
      nx = nq_q[j];
      for (int i = 0; i < 3; i++) begin
        nx.rq[i] = nq_step(nx.rq[i], nx.lo[i][KH], nx.len);
        if (KL >= 0) nx.rq[i] = nq_step(nx.rq[i], nx.lo[i][KL_S], nx.len);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) nq_q[j+1] <= nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_hit_q  <= !nq_q[NQ_STG].nm.miss;
      o_dist_q <= nq_q[NQ_STG].nm.miss ? '0 : nq_q[NQ_STG].nm.t;
      for (int i = 0; i < 3; i++) begin
        o_pt_q[i] <= nq_q[NQ_STG].nm.miss ? '0 : nq_q[NQ_STG].nm.p[i];
        if (nq_q[NQ_STG].nm.miss || nq_q[NQ_STG].nm.zero) begin
          o_nrm_q[i] <= '0;
        end else if (nq_q[NQ_STG].nm.sgn[i]) begin
          o_nrm_q[i] <= -nrm_t'(nq_q[NQ_STG].rq[i].quo);
        end else begin
          o_nrm_q[i] <= nrm_t'(nq_q[NQ_STG].rq[i].quo);
        end
      end
    end
  end

  assign m_axis_tuser = o_hit_q;
  assign m_axis_tdata = OUT_TW'({o_nrm_q[2], o_nrm_q[1], o_nrm_q[0],
                                 o_pt_q[2], o_pt_q[1], o_pt_q[0], o_dist_q});

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("miss item carries nonzero payload");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_nrm_q[0] <= NRM_ONE) && (o_nrm_q[0] >= -NRM_ONE)
                   && (o_nrm_q[1] <= NRM_ONE) && (o_nrm_q[1] >= -NRM_ONE)
                   && (o_nrm_q[2] <= NRM_ONE) && (o_nrm_q[2] >= -NRM_ONE))
    else $error("normal component beyond unit range");

endmodule
